/* sv/brsc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brsc_pkg
// Shared types and constants of the bitmap range set / clear / find block.
// ----------------------------------------------------------------------------
package brsc_pkg;

  // bitmap geometry
  localparam int WORD_BITS = 64;
  localparam int NUM_WORDS = 64;
  localparam int CAPACITY  = WORD_BITS * NUM_WORDS;

  // derived index widths
  localparam int BIT_IDX_W  = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;
  localparam int WORD_IDX_W = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;

  // item field widths
  localparam int CMD_W   = 2;
  localparam int START_W = 12;
  localparam int COUNT_W = 13;
  localparam int POS_W   = 13;
  // start plus count without overflow
  localparam int SUM_W   = COUNT_W + 1;

  // command codes
  localparam logic [CMD_W-1:0] CMD_SET       = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CLEAR     = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FIND_ZERO = 2'd2;
  localparam logic [CMD_W-1:0] CMD_FIND_SET  = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0]   command;
    logic [START_W-1:0] start_bit;
    logic [COUNT_W-1:0] count;
  } in_item_t;

  typedef struct packed {
    logic [POS_W-1:0] position;
    logic             found;
  } out_item_t;

endpackage

/* sv/bitmap_range_set_clear_find.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_range_set_clear_find
// Word-organized bitmap with range set, range clear and next-zero / next-set
// search, kept in a synchronous memory with a registered read.
// ----------------------------------------------------------------------------
// Usage:
//   An item (command, start_bit, count) is taken at a rising edge with start
//   high and busy low. Exactly one result per item appears on out_item for a
//   single cycle with out_valid high; the receiver cannot stall it.
//   The bitmap is walked one stored word per cycle: the memory read of word
//   n+1 overlaps the modify / write-back (or scan) of word n.
//   The result is registered from the processing of the item's last word;
//   a search stops at the first word holding a match. An item with an empty
//   range shows its result in the cycle after acceptance.
//   busy falls in the cycle the result is shown, so the next item can be
//   taken in that cycle; no new item is taken while one is running.
//   Reset (rst_n low, synchronous) empties the bitmap at once through one
//   valid flip-flop per word; an unwritten word reads as all zero. No
//   clearing pass is needed.
// ----------------------------------------------------------------------------
module bitmap_range_set_clear_find (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  brsc_pkg::in_item_t   in_item,
  output logic                 out_valid,
  output brsc_pkg::out_item_t  out_item
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_RUN  = 2'b10
  } state_t;

  localparam int WB  = brsc_pkg::WORD_BITS;
  localparam int BIW = brsc_pkg::BIT_IDX_W;
  localparam int WIW = brsc_pkg::WORD_IDX_W;
  localparam int SW  = brsc_pkg::SUM_W;

  // control state
  state_t                     state_r, state_nxt;
  logic                       issue_r, issue_nxt;
  logic [WIW-1:0]             rd_w_r, rd_w_nxt;
  logic                       p_vld_r, p_vld_nxt;
  logic [WIW-1:0]             p_w_r;
  logic                       out_valid_r, out_valid_nxt;
  logic [brsc_pkg::NUM_WORDS-1:0] wvalid_r;

  // item registers
  logic [brsc_pkg::CMD_W-1:0]   cmd_r;
  logic [WIW-1:0]               first_w_r, last_w_r;
  logic [BIW-1:0]               start_b_r, last_b_r;
  logic [brsc_pkg::COUNT_W-1:0] count_r;
  brsc_pkg::out_item_t          out_item_r, out_item_nxt;

  // memory
  logic [WB-1:0] mem [brsc_pkg::NUM_WORDS];
  logic [WB-1:0] rd_data_r;
  logic          rd_vbit_r;
  logic          wr_en;
  logic [WB-1:0] wr_data;

  // accept-side decode
  logic          accept;
  logic          in_search;
  logic [SW-1:0] in_sum;
  logic [SW-1:0] in_end;
  logic [SW-1:0] in_last;
  logic          in_empty;

  // word processing
  logic          is_search;
  logic [WB-1:0] p_data;
  logic [BIW-1:0] lo_b, hi_b;
  logic [WB-1:0] mask;
  logic [WB-1:0] match_v;
  logic [WB-1:0] hit_1h;
  logic [BIW-1:0] hit_b;
  logic          hit;
  logic          last_word;
  logic          finish;

  assign accept = start && !busy;
  assign busy   = (state_r != S_IDLE);

  // range end, cut at capacity
  always_comb begin
    in_search = (in_item.command == brsc_pkg::CMD_FIND_ZERO) ||
                (in_item.command == brsc_pkg::CMD_FIND_SET);
    in_sum    = SW'(in_item.start_bit) + SW'(in_item.count);
    if (in_search) begin
      in_end = SW'(in_item.count);
    end else begin
      in_end = in_sum;
    end
    if (in_end > SW'(brsc_pkg::CAPACITY)) begin
      in_end = SW'(brsc_pkg::CAPACITY);
    end
    in_empty = (SW'(in_item.start_bit) >= in_end);
    in_last  = in_end - SW'(1);
  end

  // mask of the range within the current word, match bits and write-back data
  always_comb begin
    is_search = (cmd_r == brsc_pkg::CMD_FIND_ZERO) || (cmd_r == brsc_pkg::CMD_FIND_SET);
    p_data    = rd_vbit_r ? rd_data_r : '0;
    lo_b      = (p_w_r == first_w_r) ? start_b_r : '0;
    hi_b      = (p_w_r == last_w_r) ? last_b_r : BIW'(WB - 1);
    mask      = ({WB{1'b1}} << lo_b) & ({WB{1'b1}} >> (BIW'(WB - 1) - hi_b));
    if (cmd_r == brsc_pkg::CMD_FIND_SET) begin
      match_v = p_data & mask;
    end else begin
      match_v = ~p_data & mask;
    end
    if (cmd_r == brsc_pkg::CMD_SET) begin
      wr_data = p_data | mask;
    end else begin
      wr_data = p_data & ~mask;
    end
    wr_en = p_vld_r && !is_search;
  end

  // lowest matching bit: isolate, then encode
  always_comb begin
    hit_1h = match_v & (~match_v + WB'(1));
    hit_b  = '0;
    for (int j = 0; j < WB; j++) begin
      if (hit_1h[j]) begin
        hit_b = hit_b | BIW'(j);
      end
    end
    hit       = p_vld_r && is_search && (match_v != '0);
    last_word = (p_w_r == last_w_r);
    finish    = p_vld_r && (hit || last_word);
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    issue_nxt     = issue_r;
    rd_w_nxt      = rd_w_r;
    p_vld_nxt     = 1'b0;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_empty) begin
            out_valid_nxt         = 1'b1;
            out_item_nxt.found    = 1'b0;
            out_item_nxt.position = in_search ? brsc_pkg::POS_W'(in_item.count) : '0;
          end else begin
            state_nxt = S_RUN;
            issue_nxt = 1'b1;
            rd_w_nxt  = WIW'(in_item.start_bit >> BIW);
          end
        end
      end
      S_RUN: begin
        // issue the next word read
        if (issue_r) begin
          p_vld_nxt = 1'b1;
          if (rd_w_r == last_w_r) begin
            issue_nxt = 1'b0;
          end else begin
            rd_w_nxt = rd_w_r + WIW'(1);
          end
        end
        // finish on a hit or on the last word
        if (finish) begin
          state_nxt     = S_IDLE;
          issue_nxt     = 1'b0;
          p_vld_nxt     = 1'b0;
          out_valid_nxt = 1'b1;
          out_item_nxt.found = hit;
          if (hit) begin
            out_item_nxt.position = (brsc_pkg::POS_W'(p_w_r) << BIW) |
                                    brsc_pkg::POS_W'(hit_b);
          end else if (is_search) begin
            out_item_nxt.position = brsc_pkg::POS_W'(count_r);
          end else begin
            out_item_nxt.position = '0;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
        issue_nxt = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      issue_r     <= 1'b0;
      rd_w_r      <= '0;
      p_vld_r     <= 1'b0;
      out_valid_r <= 1'b0;
      wvalid_r    <= '0;
    end else begin
      state_r     <= state_nxt;
      issue_r     <= issue_nxt;
      rd_w_r      <= rd_w_nxt;
      p_vld_r     <= p_vld_nxt;
      out_valid_r <= out_valid_nxt;
      if (wr_en) begin
        wvalid_r[p_w_r] <= 1'b1;
      end
    end
  end

  // item and payload registers
  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
    if (issue_r) begin
      p_w_r <= rd_w_r;
    end
    if (accept) begin
      cmd_r     <= in_item.command;
      count_r   <= in_item.count;
      first_w_r <= WIW'(in_item.start_bit >> BIW);
      start_b_r <= BIW'(in_item.start_bit);
      last_w_r  <= WIW'(in_last >> BIW);
      last_b_r  <= BIW'(in_last);
    end
  end

  // bitmap memory: registered read, write-back of the processed word
  always_ff @(posedge clk) begin
    if (issue_r) begin
      rd_data_r <= mem[rd_w_r];
      rd_vbit_r <= wvalid_r[rd_w_r];
    end
    if (wr_en) begin
      mem[p_w_r] <= wr_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // a word is processed only while an item is running
  a_proc_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    p_vld_r |-> (state_r == S_RUN))
    else $error("word processed outside of a running item");

  // busy only rises after an accepted item
  a_busy_rise: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(start))
    else $error("busy rose without an accepted item");

  // a result is shown only once the block is free again
  a_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while busy");

  // a found position lies below the search limit
  a_found_below: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.found) |->
      (brsc_pkg::COUNT_W'(out_item.position) < count_r))
    else $error("found position not below limit");

endmodule

/* tb/bitmap_range_set_clear_find_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_range_set_clear_find_test
// Self-checking bench for the bitmap range set / clear / find block. A short
// table of directed items hits the field extremes, every command and the edge
// cases of ranges and search limits; some rows carry a fixed expected result.
// Random items follow, with random gaps on the command side. A bit-level
// shadow of the bitmap predicts all other results, and each strobed result is
// compared field by field with the oldest pending expectation.
// ----------------------------------------------------------------------------
module bitmap_range_set_clear_find_test;

  localparam int  CLK_HALF     = 6;
  localparam int  RANDOM_ITEMS = 1125;
  localparam int  STALL_LIMIT  = 2000;
  localparam int  DRAIN_CYCLES = 80;
  localparam int  PLAN_ROWS    = 25;
  localparam bit  PREDICT      = 1'b0;
  localparam bit  FIXED        = 1'b1;

  // one row of the directed table
  typedef struct packed {
    brsc_pkg::in_item_t  item;
    bit                  fixed;
    brsc_pkg::out_item_t want;
  } plan_row_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  brsc_pkg::in_item_t  in_item = '0;
  logic                out_valid;
  brsc_pkg::out_item_t out_item;

  logic [brsc_pkg::CAPACITY-1:0] shadow_bits;
  brsc_pkg::out_item_t           pending_results[$];
  brsc_pkg::out_item_t           oldest;
  plan_row_t                     directed_plan[PLAN_ROWS];
  int                            fail_count = 0;
  int                            results_seen = 0;
  int                            found_hits = 0;
  int                            stall_cycles = 0;
  int                            cmd_tally[4] = '{0, 0, 0, 0};

  always #(CLK_HALF) clk = ~clk;

  bitmap_range_set_clear_find i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  // apply one item to the shadow bitmap and return the result it gives
  function automatic brsc_pkg::out_item_t bitmap_apply(brsc_pkg::in_item_t it);
    brsc_pkg::out_item_t r;
    int unsigned         first;
    int unsigned         stop;
    int unsigned         idx;
    logic                hunted;
    r = '0;
    first = 32'(it.start_bit);
    if (it.command == brsc_pkg::CMD_SET || it.command == brsc_pkg::CMD_CLEAR) begin
      stop = first + 32'(it.count);
      if (stop > brsc_pkg::CAPACITY) begin
        stop = brsc_pkg::CAPACITY;
      end
      for (idx = first; idx < stop; idx++) begin
        shadow_bits[idx] = (it.command == brsc_pkg::CMD_SET);
      end
      return r;
    end
    // searches never look past the bits that exist
    hunted = (it.command == brsc_pkg::CMD_FIND_SET);
    stop = (32'(it.count) < brsc_pkg::CAPACITY) ? 32'(it.count) : brsc_pkg::CAPACITY;
    for (idx = first; idx < stop; idx++) begin
      if (shadow_bits[idx] == hunted) begin
        r.position = brsc_pkg::POS_W'(idx);
        r.found    = 1'b1;
        return r;
      end
    end
    r.position = it.count;
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("%0t mismatch on %s: got %0d, want %0d (result %0d)",
             $realtime, what, got, want, results_seen);
    fail_count++;
  endtask

  // drive one item, after an idle gap when gap is nonzero; entered and left at a falling edge
  task automatic send_item(brsc_pkg::in_item_t it, int gap, bit use_fixed,
                           brsc_pkg::out_item_t fixed_want);
    brsc_pkg::out_item_t predicted;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start   <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy);
    predicted = bitmap_apply(it);
    pending_results.push_back(use_fixed ? fixed_want : predicted);
    cmd_tally[it.command]++;
    @(negedge clk);
  endtask

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", int'(out_item.position), -1);
      end else begin
        oldest = pending_results.pop_front();
        if (out_item.position !== oldest.position) begin
          report_mismatch("position", int'(out_item.position), int'(oldest.position));
        end
        if (out_item.found !== oldest.found) begin
          report_mismatch("found", int'(out_item.found), int'(oldest.found));
        end
        if (oldest.found) begin
          found_hits++;
        end
      end
      results_seen++;
    end
  end

  // watchdog on cycles where neither side moves an item
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
      $display("FAIL bitmap_range_set_clear_find");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    brsc_pkg::in_item_t it;
    int                 gap;
    int                 kind;
    bit                 no_gaps;
    int                 span;

    shadow_bits = '0;

    //  command                            start     count       check   position  found
    directed_plan = '{
      '{'{brsc_pkg::CMD_FIND_SET,  12'd0,    13'd4096}, FIXED,   '{13'd4096, 1'b0}},
      '{'{brsc_pkg::CMD_FIND_ZERO, 12'd0,    13'd4096}, FIXED,   '{13'd0,    1'b1}},
      '{'{brsc_pkg::CMD_SET,       12'd0,    13'd0},    FIXED,   '{13'd0,    1'b0}},
      '{'{brsc_pkg::CMD_FIND_ZERO, 12'd5,    13'd0},    FIXED,   '{13'd0,    1'b0}},
      '{'{brsc_pkg::CMD_FIND_ZERO, 12'd10,   13'd5},    FIXED,   '{13'd5,    1'b0}},
      '{'{brsc_pkg::CMD_SET,       12'd4090, 13'd4096}, FIXED,   '{13'd0,    1'b0}},
      '{'{brsc_pkg::CMD_FIND_SET,  12'd0,    13'd8191}, PREDICT, '{13'd0,    1'b0}},
      '{'{brsc_pkg::CMD_FIND_ZERO, 12'd4090, 13'd8191}, PREDICT, '{13'd0,    1'b0}},
      '{'{brsc_pkg::CMD_CLEAR,     12'd0,    13'd8191}, FIXED,   '{13'd0,    1'b0}},
      '{'{brsc_pkg::CMD_FIND_SET,  12'd0,    13'd8191}, FIXED,   '{13'd8191, 1'b0}},
      '{'{brsc_pkg::CMD_SET,       12'd63,   13'd2},    FIXED,   '{13'd0,    1'b0}},
      '{'{brsc_pkg::CMD_FIND_SET,  12'd0,    13'd4096}, PREDICT, '{13'd0,    1'b0}},
      '{'{brsc_pkg::CMD_FIND_ZERO, 12'd63,   13'd100},  PREDICT, '{13'd0,    1'b0}},
      '{'{brsc_pkg::CMD_SET,       12'd4095, 13'd1},    FIXED,   '{13'd0,    1'b0}},
      '{'{brsc_pkg::CMD_FIND_SET,  12'd65,   13'd4095}, PREDICT, '{13'd0,    1'b0}},
      '{'{brsc_pkg::CMD_SET,       12'd0,    13'd4096}, FIXED,   '{13'd0,    1'b0}},
      '{'{brsc_pkg::CMD_FIND_ZERO, 12'd0,    13'd4096}, FIXED,   '{13'd4096, 1'b0}},
      '{'{brsc_pkg::CMD_FIND_SET,  12'd4095, 13'd4096}, FIXED,   '{13'd4095, 1'b1}},
      '{'{brsc_pkg::CMD_CLEAR,     12'd100,  13'd50},   FIXED,   '{13'd0,    1'b0}},
      '{'{brsc_pkg::CMD_FIND_ZERO, 12'd0,    13'd4096}, PREDICT, '{13'd0,    1'b0}},
      '{'{brsc_pkg::CMD_FIND_SET,  12'd100,  13'd150},  PREDICT, '{13'd0,    1'b0}},
      '{'{brsc_pkg::CMD_CLEAR,     12'd4095, 13'd8191}, FIXED,   '{13'd0,    1'b0}},
      '{'{brsc_pkg::CMD_FIND_ZERO, 12'd4000, 13'd8191}, PREDICT, '{13'd0,    1'b0}},
      '{'{brsc_pkg::CMD_FIND_ZERO, 12'd4095, 13'd4095}, FIXED,   '{13'd4095, 1'b0}},
      '{'{brsc_pkg::CMD_SET,       12'd4095, 13'd0},    FIXED,   '{13'd0,    1'b0}}
    };

    // hold reset, then release it
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed table
    for (int n = 0; n < PLAN_ROWS; n++) begin
      send_item(directed_plan[n].item, $urandom_range(0, 3),
                directed_plan[n].fixed, directed_plan[n].want);
    end

    // random items, with bursts that never idle
    no_gaps = 1'b0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 64 == 0) begin
        no_gaps = ($urandom_range(0, 3) == 0);
      end
      gap = no_gaps ? 0 : $urandom_range(0, 11);
      it.command   = brsc_pkg::CMD_W'($urandom_range(0, 3));
      it.start_bit = brsc_pkg::START_W'($urandom_range(0, brsc_pkg::CAPACITY - 1));
      // word-aligned starts now and then
      if ($urandom_range(0, 4) == 0) begin
        it.start_bit = brsc_pkg::START_W'(brsc_pkg::WORD_BITS *
                                          $urandom_range(0, brsc_pkg::NUM_WORDS - 1));
      end
      kind = $urandom_range(0, 19);
      if (kind == 0) begin
        it.count = '0;
      end else if (kind == 1) begin
        it.count = brsc_pkg::COUNT_W'($urandom_range(brsc_pkg::CAPACITY + 1, 8191));
      end else if (kind == 2) begin
        it.count = brsc_pkg::COUNT_W'($urandom_range(0, 8191));
      end else if (it.command == brsc_pkg::CMD_SET || it.command == brsc_pkg::CMD_CLEAR) begin
        it.count = brsc_pkg::COUNT_W'($urandom_range(1, 400));
      end else begin
        // first-bit search now and then; the limit lies a little past start
        if (kind == 3) begin
          it.start_bit = '0;
        end
        span = 32'(it.start_bit) + $urandom_range(0, 600);
        it.count = (span > 8191) ? 13'd8191 : brsc_pkg::COUNT_W'(span);
      end
      send_item(it, gap, PREDICT, '0);
    end
    start <= 1'b0;

    // drain: the watchdog ends the run if results stop coming
    while (pending_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d set, %0d clear, %0d find-zero, %0d find-set items",
             cmd_tally[brsc_pkg::CMD_SET], cmd_tally[brsc_pkg::CMD_CLEAR],
             cmd_tally[brsc_pkg::CMD_FIND_ZERO], cmd_tally[brsc_pkg::CMD_FIND_SET]);
    $display("checked %0d results, %0d searches hit, %0d mismatches",
             results_seen, found_hits, fail_count);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("PASS bitmap_range_set_clear_find");
    end else begin
      $display("FAIL bitmap_range_set_clear_find");
    end
    $finish;
  end

endmodule

/* bitmap_range_set_clear_find.f */
sv/brsc_pkg.sv
sv/bitmap_range_set_clear_find.sv
tb/bitmap_range_set_clear_find_test.sv
